// ===== src/atcs_pkg.sv =====
package atcs_pkg;

  // Item kinds carried in the action field.
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_START = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Sequences that a start item can launch.
  typedef enum logic [2:0] {
    CMD_RESET     = 3'd0,
    CMD_HANDSHAKE = 3'd1,
    CMD_SET_PIN   = 3'd2,
    CMD_SET_ROLE  = 3'd3,
    CMD_SET_BAUD  = 3'd4
  } command_t;

  // Module commands put on the serial line.
  typedef enum logic [2:0] {
    SEND_NONE = 3'd0,
    SEND_AT   = 3'd1,
    SEND_PIN  = 3'd2,
    SEND_ROLE = 3'd3,
    SEND_BAUD = 3'd4
  } send_kind_t;

  // Link classification of the status pin.
  typedef enum logic [1:0] {
    LINK_TRANSPARENT = 2'd0,
    LINK_COMMAND     = 2'd1,
    LINK_ABSENT      = 2'd2
  } link_mode_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SAMPLE_PERIOD     = 3'd0,
    CFG_WINDOW_SAMPLES    = 3'd1,
    CFG_RESPONSE_TIMEOUT  = 3'd2,
    CFG_POWER_OFF_TIME    = 3'd3,
    CFG_POWER_SETTLE_TIME = 3'd4,
    CFG_KEY_PULSE_TIME    = 3'd5,
    CFG_COMMAND_GAP       = 3'd6
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE       = 5'd0,
    S_PWR_CUT    = 5'd1,
    S_PWR_WAIT   = 5'd2,
    S_SETTLE     = 5'd3,
    S_HS_START   = 5'd4,
    S_HS_WAIT    = 5'd5,
    S_PIN_START  = 5'd6,
    S_PIN_WAIT   = 5'd7,
    S_ROLE_START = 5'd8,
    S_ROLE_WAIT  = 5'd9,
    S_GAP        = 5'd10,
    S_BAUD_START = 5'd11,
    S_BAUD_WAIT  = 5'd12,
    S_KEY_START  = 5'd13,
    S_KEY_WAIT   = 5'd14,
    S_DELAY_OFF  = 5'd15,
    S_DELAY_ON   = 5'd16
  } run_state_t;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 3;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_SAMPLE_PERIOD     = 8'd10;
  localparam logic [7:0]  RST_WINDOW_SAMPLES    = 8'd100;
  localparam logic [15:0] RST_RESPONSE_TIMEOUT  = 16'd1000;
  localparam logic [15:0] RST_POWER_OFF_TIME    = 16'd500;
  localparam logic [15:0] RST_POWER_SETTLE_TIME = 16'd2000;
  localparam logic [15:0] RST_KEY_PULSE_TIME    = 16'd200;
  localparam logic [15:0] RST_COMMAND_GAP       = 16'd1500;

  // Fixed delays after a successful reply.
  localparam logic [15:0] HS_OFF_DELAY   = 16'd100;
  localparam logic [15:0] PIN_ON_DELAY   = 16'd2000;
  localparam logic [15:0] BAUD_OFF_DELAY = 16'd1500;

  localparam logic [17:0] AUTO_BAUD  = 18'd9600;
  localparam logic [17:0] RST_BAUD   = 18'd4;

  // Reply lengths armed for each command.
  localparam logic [3:0] REPLY_LEN_AT   = 4'd2;
  localparam logic [3:0] REPLY_LEN_PIN  = 4'd8;
  localparam logic [3:0] REPLY_LEN_ROLE = 4'd9;
  localparam logic [3:0] REPLY_LEN_BAUD = 4'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic        led_level;
    logic        rx_done;
    logic        rx_match;
    logic [2:0]  command;
    logic [31:0] password;
    logic [17:0] baud_rate;
  } in_item_t;

  typedef struct packed {
    logic        power_off;
    logic        key_high;
    logic [2:0]  send_kind;
    logic [31:0] send_arg;
    logic [3:0]  reply_length;
    logic [1:0]  link_mode;
    logic        error;
    logic        done_res;
    logic        busy_res;
  } out_item_t;

  // Control from the sequencer to the link monitor.
  typedef struct packed {
    logic tick;
    logic led;
    logic clear;
  } mon_ctl_t;

  // Baud rate to the module's rate code; unknown rates give code zero.
  function automatic logic [3:0] baud_code(input logic [17:0] rate);
    logic [3:0] code;
    case (rate)
      18'd1200:   code = 4'd1;
      18'd2400:   code = 4'd2;
      18'd4800:   code = 4'd3;
      18'd9600:   code = 4'd4;
      18'd19200:  code = 4'd5;
      18'd38400:  code = 4'd6;
      18'd57600:  code = 4'd7;
      18'd115200: code = 4'd8;
      18'd230400: code = 4'd9;
      default:    code = 4'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== src/atcs_link_monitor.sv =====
module atcs_link_monitor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           sample_period,
  input  logic [7:0]           window_samples,
  input  atcs_pkg::mon_ctl_t   ctl,
  output atcs_pkg::link_mode_t mode,
  output atcs_pkg::link_mode_t mode_next
);

  logic [7:0] sample_divider, sample_divider_next;
  logic [7:0] high_count, high_count_next;
  logic [7:0] sample_count, sample_count_next;
  logic [7:0] high_inc;
  logic [7:0] sample_inc;

  // Sample divider, window counters and classification at window end.
  always_comb begin
    sample_divider_next = sample_divider;
    high_count_next     = high_count;
    sample_count_next   = sample_count;
    mode_next           = mode;
    high_inc            = high_count + {7'd0, ctl.led};
    sample_inc          = sample_count + 8'd1;
    if (ctl.clear) begin
      sample_divider_next = sample_period;
      high_count_next     = 8'd0;
      sample_count_next   = 8'd0;
    end else if (ctl.tick) begin
      if (sample_divider != 8'd0) begin
        sample_divider_next = sample_divider - 8'd1;
      end else begin
        sample_divider_next = sample_period;
        high_count_next     = high_inc;
        sample_count_next   = sample_inc;
        if (sample_inc >= window_samples) begin
          if (high_inc == window_samples) begin
            mode_next = atcs_pkg::LINK_TRANSPARENT;
          end else if (high_inc == 8'd0) begin
            mode_next = atcs_pkg::LINK_ABSENT;
          end else begin
            mode_next = atcs_pkg::LINK_COMMAND;
          end
          high_count_next   = 8'd0;
          sample_count_next = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_divider <= atcs_pkg::RST_SAMPLE_PERIOD;
      high_count     <= 8'd0;
      sample_count   <= 8'd0;
      mode           <= atcs_pkg::LINK_COMMAND;
    end else begin
      sample_divider <= sample_divider_next;
      high_count     <= high_count_next;
      sample_count   <= sample_count_next;
      mode           <= mode_next;
    end
  end

  // A clear empties both window counters for the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (sample_count == 8'd0 && high_count == 8'd0))
    else $error("link monitor counters not cleared");

  assert property (@(posedge clk) disable iff (rst)
    high_count_next != high_count |-> ctl.tick || ctl.clear)
    else $error("high count moved without a tick or clear");

  assert property (@(posedge clk) disable iff (rst)
    mode_next != mode |-> ctl.tick && sample_divider == 8'd0)
    else $error("link mode changed off a sample");

endmodule

// ===== src/at_module_config_sequencer.sv =====
// Channel   Direction  Handshake               Payload
// item      in         item_valid/item_stall   atcs_pkg::in_item_t
// result    out        result_valid/result_stall atcs_pkg::out_item_t
// cfg       in         cfg_we                  cfg_index, cfg_data
//
// An accepted item is held in the input register, then the sequencer, timer
// and link monitor update and its result is registered in the result register;
// one item per cycle is sustained while the result side does not stall.
// Each item yields exactly one result item.
// Reset is synchronous; there is no clearing pass.
// A stalled result holds the input register, which then stalls the item side.
module at_module_config_sequencer #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  atcs_pkg::in_item_t                  item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output atcs_pkg::out_item_t                 result,
  input  logic                                cfg_we,
  input  logic [atcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [atcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_WIDTH) - 33'd1;

  // Timer load with saturation at the timer's maximum.
  function automatic logic [TIMER_WIDTH-1:0] sat_load(input logic [15:0] v);
    logic [32:0] wide;
    wide = {17'd0, v};
    if (wide > TIMER_MAX) begin
      wide = TIMER_MAX;
    end
    return wide[TIMER_WIDTH-1:0];
  endfunction

  // Configuration registers.
  logic [7:0]  sample_period;
  logic [7:0]  window_samples;
  logic [15:0] response_timeout;
  logic [15:0] power_off_time;
  logic [15:0] power_settle_time;
  logic [15:0] key_pulse_time;
  logic [15:0] command_gap;

  // Input register and handshake.
  logic               q_valid;
  atcs_pkg::in_item_t q_item;
  logic               advance;
  logic               proc;

  // Sequencer state.
  atcs_pkg::run_state_t   run_state, run_state_next;
  atcs_pkg::run_state_t   return_state, return_state_next;
  logic [TIMER_WIDTH-1:0] delay_timer, delay_timer_next;
  logic                   error_flag, error_flag_next;
  logic                   done_flag, done_flag_next;
  logic [31:0]            stored_pin, stored_pin_next;
  logic [17:0]            stored_baud, stored_baud_next;
  logic                   power_off_level, power_off_level_next;
  logic                   key_level, key_level_next;

  // Shared command start and reply wait handling.
  logic                   cmd_go;
  atcs_pkg::send_kind_t   cmd_kind;
  logic [31:0]            cmd_arg;
  logic [3:0]             cmd_len;
  atcs_pkg::run_state_t   cmd_next;
  logic                   wait_go;
  atcs_pkg::run_state_t   wait_next;
  logic [15:0]            wait_delay;
  logic                   timer_zero;

  atcs_pkg::send_kind_t   send_kind;
  logic [31:0]            send_arg;
  logic [3:0]             reply_length;

  atcs_pkg::mon_ctl_t     mon_ctl;
  atcs_pkg::link_mode_t   mode_now;
  atcs_pkg::link_mode_t   mode_next;
  atcs_pkg::out_item_t    result_next;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period     <= atcs_pkg::RST_SAMPLE_PERIOD;
      window_samples    <= atcs_pkg::RST_WINDOW_SAMPLES;
      response_timeout  <= atcs_pkg::RST_RESPONSE_TIMEOUT;
      power_off_time    <= atcs_pkg::RST_POWER_OFF_TIME;
      power_settle_time <= atcs_pkg::RST_POWER_SETTLE_TIME;
      key_pulse_time    <= atcs_pkg::RST_KEY_PULSE_TIME;
      command_gap       <= atcs_pkg::RST_COMMAND_GAP;
    end else if (cfg_we) begin
      case (cfg_index)
        atcs_pkg::CFG_SAMPLE_PERIOD:     sample_period     <= cfg_data[7:0];
        atcs_pkg::CFG_WINDOW_SAMPLES:    window_samples    <= cfg_data[7:0];
        atcs_pkg::CFG_RESPONSE_TIMEOUT:  response_timeout  <= cfg_data;
        atcs_pkg::CFG_POWER_OFF_TIME:    power_off_time    <= cfg_data;
        atcs_pkg::CFG_POWER_SETTLE_TIME: power_settle_time <= cfg_data;
        atcs_pkg::CFG_KEY_PULSE_TIME:    key_pulse_time    <= cfg_data;
        atcs_pkg::CFG_COMMAND_GAP:       command_gap       <= cfg_data;
        default: ;
      endcase
    end
  end

  // The held item moves on when the result register is free or being taken.
  assign advance    = !result_valid || !result_stall;
  assign proc       = q_valid && advance;
  assign item_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!item_stall) begin
      q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      q_item <= item;
    end
  end

  // Sequencer next state, timer and the command sent by this item.
  always_comb begin
    run_state_next       = run_state;
    return_state_next    = return_state;
    delay_timer_next     = delay_timer;
    error_flag_next      = error_flag;
    done_flag_next       = done_flag;
    stored_pin_next      = stored_pin;
    stored_baud_next     = stored_baud;
    power_off_level_next = power_off_level;
    key_level_next       = key_level;
    send_kind            = atcs_pkg::SEND_NONE;
    send_arg             = 32'd0;
    reply_length         = 4'd0;
    cmd_go               = 1'b0;
    cmd_kind             = atcs_pkg::SEND_NONE;
    cmd_arg              = 32'd0;
    cmd_len              = 4'd0;
    cmd_next             = atcs_pkg::S_IDLE;
    wait_go              = 1'b0;
    wait_next            = atcs_pkg::S_IDLE;
    wait_delay           = 16'd0;
    mon_ctl              = '0;
    timer_zero           = (delay_timer == '0);

    if (proc) begin
      case (q_item.action)
        atcs_pkg::ACT_TICK: begin
          if (!timer_zero) begin
            delay_timer_next = delay_timer - TIMER_WIDTH'(1);
          end
          mon_ctl.tick = 1'b1;
          mon_ctl.led  = q_item.led_level;
        end
        atcs_pkg::ACT_STEP: begin
          case (run_state)
            atcs_pkg::S_PWR_CUT: begin
              power_off_level_next = 1'b1;
              delay_timer_next     = sat_load(power_off_time);
              run_state_next       = atcs_pkg::S_PWR_WAIT;
            end
            atcs_pkg::S_PWR_WAIT: begin
              if (timer_zero) begin
                power_off_level_next = 1'b0;
                delay_timer_next     = sat_load(power_settle_time);
                run_state_next       = atcs_pkg::S_SETTLE;
                error_flag_next      = 1'b0;
                done_flag_next       = 1'b0;
                mon_ctl.clear        = 1'b1;
              end
            end
            atcs_pkg::S_SETTLE: begin
              if (timer_zero) begin
                run_state_next = return_state;
              end
            end
            atcs_pkg::S_HS_START: begin
              cmd_go   = 1'b1;
              cmd_kind = atcs_pkg::SEND_AT;
              cmd_len  = atcs_pkg::REPLY_LEN_AT;
              cmd_next = atcs_pkg::S_HS_WAIT;
            end
            atcs_pkg::S_HS_WAIT: begin
              wait_go    = 1'b1;
              wait_next  = atcs_pkg::S_DELAY_OFF;
              wait_delay = atcs_pkg::HS_OFF_DELAY;
            end
            atcs_pkg::S_PIN_START: begin
              cmd_go   = 1'b1;
              cmd_kind = atcs_pkg::SEND_PIN;
              cmd_arg  = stored_pin;
              cmd_len  = atcs_pkg::REPLY_LEN_PIN;
              cmd_next = atcs_pkg::S_PIN_WAIT;
            end
            atcs_pkg::S_PIN_WAIT: begin
              wait_go    = 1'b1;
              wait_next  = atcs_pkg::S_DELAY_ON;
              wait_delay = atcs_pkg::PIN_ON_DELAY;
            end
            atcs_pkg::S_ROLE_START: begin
              cmd_go   = 1'b1;
              cmd_kind = atcs_pkg::SEND_ROLE;
              cmd_len  = atcs_pkg::REPLY_LEN_ROLE;
              cmd_next = atcs_pkg::S_ROLE_WAIT;
            end
            atcs_pkg::S_ROLE_WAIT: begin
              wait_go    = 1'b1;
              wait_next  = atcs_pkg::S_GAP;
              wait_delay = command_gap;
            end
            atcs_pkg::S_GAP: begin
              if (timer_zero) begin
                stored_baud_next = atcs_pkg::AUTO_BAUD;
                run_state_next   = atcs_pkg::S_BAUD_START;
              end
            end
            atcs_pkg::S_BAUD_START: begin
              cmd_go   = 1'b1;
              cmd_kind = atcs_pkg::SEND_BAUD;
              cmd_arg  = {28'd0, atcs_pkg::baud_code(stored_baud)};
              cmd_len  = atcs_pkg::REPLY_LEN_BAUD;
              cmd_next = atcs_pkg::S_BAUD_WAIT;
            end
            atcs_pkg::S_BAUD_WAIT: begin
              wait_go    = 1'b1;
              wait_next  = atcs_pkg::S_DELAY_OFF;
              wait_delay = atcs_pkg::BAUD_OFF_DELAY;
            end
            atcs_pkg::S_KEY_START: begin
              key_level_next   = 1'b1;
              delay_timer_next = sat_load(key_pulse_time);
              run_state_next   = atcs_pkg::S_KEY_WAIT;
            end
            atcs_pkg::S_KEY_WAIT: begin
              if (timer_zero) begin
                key_level_next = 1'b0;
                done_flag_next = 1'b1;
                run_state_next = atcs_pkg::S_IDLE;
              end
            end
            atcs_pkg::S_DELAY_OFF: begin
              if (timer_zero) begin
                power_off_level_next = 1'b1;
                delay_timer_next     = sat_load(power_off_time);
                run_state_next       = atcs_pkg::S_DELAY_ON;
              end
            end
            atcs_pkg::S_DELAY_ON: begin
              if (timer_zero) begin
                power_off_level_next = 1'b0;
                done_flag_next       = 1'b1;
                run_state_next       = atcs_pkg::S_IDLE;
              end
            end
            default: begin
              run_state_next = atcs_pkg::S_IDLE;
            end
          endcase

          // Command start: send only in command mode, otherwise fail.
          if (cmd_go) begin
            if (mode_now == atcs_pkg::LINK_COMMAND) begin
              send_kind        = cmd_kind;
              send_arg         = cmd_arg;
              reply_length     = cmd_len;
              delay_timer_next = sat_load(response_timeout);
              run_state_next   = cmd_next;
            end else begin
              run_state_next  = atcs_pkg::S_IDLE;
              error_flag_next = 1'b1;
            end
          end

          // Reply wait: timeout first, then the reply check.
          if (wait_go) begin
            if (timer_zero) begin
              run_state_next  = atcs_pkg::S_IDLE;
              error_flag_next = 1'b1;
            end else if (q_item.rx_done) begin
              if (q_item.rx_match) begin
                run_state_next   = wait_next;
                delay_timer_next = sat_load(wait_delay);
              end else begin
                run_state_next = atcs_pkg::S_IDLE;
              end
            end
          end
        end
        atcs_pkg::ACT_START: begin
          case (q_item.command)
            atcs_pkg::CMD_RESET: begin
              run_state_next    = atcs_pkg::S_PWR_CUT;
              return_state_next = atcs_pkg::S_KEY_START;
            end
            atcs_pkg::CMD_HANDSHAKE: begin
              run_state_next  = atcs_pkg::S_HS_START;
              error_flag_next = 1'b0;
              done_flag_next  = 1'b0;
              mon_ctl.clear   = 1'b1;
            end
            atcs_pkg::CMD_SET_PIN: begin
              stored_pin_next = q_item.password;
              run_state_next  = atcs_pkg::S_PIN_START;
              error_flag_next = 1'b0;
              done_flag_next  = 1'b0;
              mon_ctl.clear   = 1'b1;
            end
            atcs_pkg::CMD_SET_ROLE: begin
              run_state_next  = atcs_pkg::S_ROLE_START;
              error_flag_next = 1'b0;
              done_flag_next  = 1'b0;
              mon_ctl.clear   = 1'b1;
            end
            atcs_pkg::CMD_SET_BAUD: begin
              stored_baud_next = q_item.baud_rate;
              run_state_next   = atcs_pkg::S_BAUD_START;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  atcs_link_monitor u_link_monitor (
    .clk            (clk),
    .rst            (rst),
    .sample_period  (sample_period),
    .window_samples (window_samples),
    .ctl            (mon_ctl),
    .mode           (mode_now),
    .mode_next      (mode_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      run_state       <= atcs_pkg::S_IDLE;
      return_state    <= atcs_pkg::S_IDLE;
      delay_timer     <= '0;
      error_flag      <= 1'b0;
      done_flag       <= 1'b0;
      stored_pin      <= 32'd0;
      stored_baud     <= atcs_pkg::RST_BAUD;
      power_off_level <= 1'b0;
      key_level       <= 1'b0;
    end else begin
      run_state       <= run_state_next;
      return_state    <= return_state_next;
      delay_timer     <= delay_timer_next;
      error_flag      <= error_flag_next;
      done_flag       <= done_flag_next;
      stored_pin      <= stored_pin_next;
      stored_baud     <= stored_baud_next;
      power_off_level <= power_off_level_next;
      key_level       <= key_level_next;
    end
  end

  // Result item reflects the state after the item.
  always_comb begin
    result_next.power_off    = power_off_level_next;
    result_next.key_high     = key_level_next;
    result_next.send_kind    = send_kind;
    result_next.send_arg     = send_arg;
    result_next.reply_length = reply_length;
    result_next.link_mode    = mode_next;
    result_next.error        = error_flag_next;
    result_next.done_res     = done_flag_next;
    result_next.busy_res     = (run_state_next != atcs_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      result <= result_next;
    end
  end

  // A processed item always leaves a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    proc |=> result_valid)
    else $error("processed item produced no result");

  // Any command sent arms the receiver.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.send_kind != atcs_pkg::SEND_NONE |-> result.reply_length != 4'd0)
    else $error("command sent without a reply length");

  // A tick counts a running timer down by one.
  assert property (@(posedge clk) disable iff (rst)
    proc && q_item.action == atcs_pkg::ACT_TICK && delay_timer != '0
    |=> delay_timer == $past(delay_timer) - TIMER_WIDTH'(1))
    else $error("delay timer did not count down on tick");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned TIMER_W = 16;
  localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_W) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int NUM_PHASES = 7;
  localparam int PRINT_CAP = 100;

  // Fixed delays and reply lengths of the sequencer, kept apart from the RTL.
  localparam logic [15:0] AT_OFF_TICKS = 16'd100;
  localparam logic [15:0] PIN_ON_TICKS = 16'd2000;
  localparam logic [15:0] BAUD_OFF_TICKS = 16'd1500;
  localparam logic [17:0] GAP_BAUD_RATE = 18'd9600;
  localparam logic [3:0] AT_REPLY = 4'd2;
  localparam logic [3:0] PIN_REPLY = 4'd8;
  localparam logic [3:0] ROLE_REPLY = 4'd9;
  localparam logic [3:0] BAUD_REPLY = 4'd6;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [7:0]  period;
    logic [7:0]  window;
    logic [15:0] resp;
    logic [15:0] poff;
    logic [15:0] settle;
    logic [15:0] keyt;
    logic [15:0] gap;
  } settings_t;

  typedef struct {
    atcs_pkg::in_item_t  stim;
    bit                  typed;
    atcs_pkg::out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  atcs_pkg::in_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  atcs_pkg::out_item_t result;
  logic cfg_we = 1'b0;
  logic [atcs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [atcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  at_module_config_sequencer u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor copy of the configuration registers.
  logic [7:0]  c_period = 8'd10;
  logic [7:0]  c_window = 8'd100;
  logic [15:0] c_resp = 16'd1000;
  logic [15:0] c_poff = 16'd500;
  logic [15:0] c_settle = 16'd2000;
  logic [15:0] c_key = 16'd200;
  logic [15:0] c_gap = 16'd1500;

  // Predictor copy of the sequencer and link monitor state.
  atcs_pkg::run_state_t seq_state = atcs_pkg::S_IDLE;
  atcs_pkg::run_state_t seq_return = atcs_pkg::S_IDLE;
  logic [TIMER_W-1:0] seq_timer = '0;
  logic [7:0] sample_div = 8'd10;
  logic [7:0] led_highs = '0;
  logic [7:0] led_samples = '0;
  atcs_pkg::link_mode_t link_now = atcs_pkg::LINK_COMMAND;
  logic err_now = 1'b0;
  logic done_now = 1'b0;
  logic [31:0] pin_now = '0;
  logic [17:0] baud_now = 18'd4;
  logic pwr_cut = 1'b0;
  logic key_on = 1'b0;

  logic [17:0] known_rates [0:8] = '{18'd1200, 18'd2400, 18'd4800, 18'd9600, 18'd19200,
                                    18'd38400, 18'd57600, 18'd115200, 18'd230400};

  atcs_pkg::out_item_t pending_results [$];
  dir_row_t dir_table [$];
  settings_t phase_settings [NUM_PHASES];
  int phase_send_idle [NUM_PHASES] = '{0, 50, 0, 30, 0, 50, 30};
  int phase_stall [NUM_PHASES] = '{0, 0, 50, 30, 0, 0, 30};

  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  atcs_pkg::out_item_t oldest;

  // Timer loads saturate at the width of the timer.
  function automatic void load_timer(input logic [15:0] ticks);
    if (ticks > TIMER_MAX) seq_timer = TIMER_MAX[TIMER_W-1:0];
    else seq_timer = ticks[TIMER_W-1:0];
  endfunction

  // A new sequence clears the flags and restarts the sampling window.
  function automatic void restart_window();
    err_now = 1'b0;
    done_now = 1'b0;
    sample_div = c_period;
    led_highs = '0;
    led_samples = '0;
  endfunction

  // Unknown rates map to code zero.
  function automatic logic [3:0] rate_code(input logic [17:0] rate);
    logic [3:0] code;
    code = '0;
    for (int i = 0; i < 9; i++) begin
      if (known_rates[i] == rate) code = 4'(i + 1);
    end
    return code;
  endfunction

  // A tick counts the timer down and samples the status pin when the sample divider runs out.
  function automatic void sample_led(input logic led);
    if (seq_timer != 0) seq_timer = seq_timer - TIMER_W'(1);
    if (sample_div != 0) begin
      sample_div = sample_div - 8'd1;
    end else begin
      sample_div = c_period;
      if (led) led_highs = led_highs + 8'd1;
      led_samples = led_samples + 8'd1;
      if (led_samples >= c_window) begin
        if (led_highs == c_window) link_now = atcs_pkg::LINK_TRANSPARENT;
        else if (led_highs == 0) link_now = atcs_pkg::LINK_ABSENT;
        else link_now = atcs_pkg::LINK_COMMAND;
        led_samples = '0;
        led_highs = '0;
      end
    end
  endfunction

  // A command goes out only in command mode; otherwise the sequence fails.
  function automatic void issue_command(input atcs_pkg::send_kind_t kind,
                                        input logic [31:0] arg, input logic [3:0] len,
                                        input atcs_pkg::run_state_t nxt,
                                        inout atcs_pkg::out_item_t r);
    if (link_now == atcs_pkg::LINK_COMMAND) begin
      r.send_kind = kind;
      r.send_arg = arg;
      r.reply_length = len;
      load_timer(c_resp);
      seq_state = nxt;
    end else begin
      seq_state = atcs_pkg::S_IDLE;
      err_now = 1'b1;
    end
  endfunction

  // Timeout wins over a reply; a wrong reply quietly returns to idle.
  function automatic void await_reply(input logic got, input logic ok,
                                      input atcs_pkg::run_state_t nxt,
                                      input logic [15:0] dly);
    if (seq_timer == 0) begin
      seq_state = atcs_pkg::S_IDLE;
      err_now = 1'b1;
    end else if (got) begin
      seq_state = atcs_pkg::S_IDLE;
      if (ok) begin
        seq_state = nxt;
        load_timer(dly);
      end
    end
  endfunction

  function automatic void step_sequencer(input logic got, input logic ok,
                                         inout atcs_pkg::out_item_t r);
    case (seq_state)
      atcs_pkg::S_PWR_CUT: begin
        pwr_cut = 1'b1;
        load_timer(c_poff);
        seq_state = atcs_pkg::S_PWR_WAIT;
      end
      atcs_pkg::S_PWR_WAIT: begin
        if (seq_timer == 0) begin
          pwr_cut = 1'b0;
          load_timer(c_settle);
          seq_state = atcs_pkg::S_SETTLE;
          restart_window();
        end
      end
      atcs_pkg::S_SETTLE: begin
        if (seq_timer == 0) seq_state = seq_return;
      end
      atcs_pkg::S_HS_START:
        issue_command(atcs_pkg::SEND_AT, '0, AT_REPLY, atcs_pkg::S_HS_WAIT, r);
      atcs_pkg::S_HS_WAIT: await_reply(got, ok, atcs_pkg::S_DELAY_OFF, AT_OFF_TICKS);
      atcs_pkg::S_PIN_START:
        issue_command(atcs_pkg::SEND_PIN, pin_now, PIN_REPLY, atcs_pkg::S_PIN_WAIT, r);
      atcs_pkg::S_PIN_WAIT: await_reply(got, ok, atcs_pkg::S_DELAY_ON, PIN_ON_TICKS);
      atcs_pkg::S_ROLE_START:
        issue_command(atcs_pkg::SEND_ROLE, '0, ROLE_REPLY, atcs_pkg::S_ROLE_WAIT, r);
      atcs_pkg::S_ROLE_WAIT: await_reply(got, ok, atcs_pkg::S_GAP, c_gap);
      atcs_pkg::S_GAP: begin
        if (seq_timer == 0) begin
          baud_now = GAP_BAUD_RATE;
          seq_state = atcs_pkg::S_BAUD_START;
        end
      end
      atcs_pkg::S_BAUD_START:
        issue_command(atcs_pkg::SEND_BAUD, {28'd0, rate_code(baud_now)}, BAUD_REPLY,
                      atcs_pkg::S_BAUD_WAIT, r);
      atcs_pkg::S_BAUD_WAIT:
        await_reply(got, ok, atcs_pkg::S_DELAY_OFF, BAUD_OFF_TICKS);
      atcs_pkg::S_KEY_START: begin
        key_on = 1'b1;
        load_timer(c_key);
        seq_state = atcs_pkg::S_KEY_WAIT;
      end
      atcs_pkg::S_KEY_WAIT: begin
        if (seq_timer == 0) begin
          key_on = 1'b0;
          done_now = 1'b1;
          seq_state = atcs_pkg::S_IDLE;
        end
      end
      atcs_pkg::S_DELAY_OFF: begin
        if (seq_timer == 0) begin
          pwr_cut = 1'b1;
          load_timer(c_poff);
          seq_state = atcs_pkg::S_DELAY_ON;
        end
      end
      atcs_pkg::S_DELAY_ON: begin
        if (seq_timer == 0) begin
          pwr_cut = 1'b0;
          done_now = 1'b1;
          seq_state = atcs_pkg::S_IDLE;
        end
      end
      default: seq_state = atcs_pkg::S_IDLE;
    endcase
  endfunction

  // A start item with a known command replaces whatever sequence is running.
  function automatic void launch(input logic [2:0] cmd, input logic [31:0] pw,
                                 input logic [17:0] rate);
    case (cmd)
      atcs_pkg::CMD_RESET: begin
        seq_state = atcs_pkg::S_PWR_CUT;
        seq_return = atcs_pkg::S_KEY_START;
      end
      atcs_pkg::CMD_HANDSHAKE: begin
        seq_state = atcs_pkg::S_HS_START;
        restart_window();
      end
      atcs_pkg::CMD_SET_PIN: begin
        pin_now = pw;
        seq_state = atcs_pkg::S_PIN_START;
        restart_window();
      end
      atcs_pkg::CMD_SET_ROLE: begin
        seq_state = atcs_pkg::S_ROLE_START;
        restart_window();
      end
      atcs_pkg::CMD_SET_BAUD: begin
        baud_now = rate;
        seq_state = atcs_pkg::S_BAUD_START;
      end
      default: ;
    endcase
  endfunction

  // Applies one item to the predicted state and returns the result it yields.
  function automatic atcs_pkg::out_item_t advance_sequencer(input atcs_pkg::in_item_t it);
    atcs_pkg::out_item_t r;
    r = '0;
    case (it.action)
      atcs_pkg::ACT_TICK: sample_led(it.led_level);
      atcs_pkg::ACT_STEP: step_sequencer(it.rx_done, it.rx_match, r);
      atcs_pkg::ACT_START: launch(it.command, it.password, it.baud_rate);
      default: ;
    endcase
    r.power_off = pwr_cut;
    r.key_high = key_on;
    r.link_mode = link_now;
    r.error = err_now;
    r.done_res = done_now;
    r.busy_res = (seq_state != atcs_pkg::S_IDLE);
    return r;
  endfunction

  function automatic atcs_pkg::in_item_t stim(input atcs_pkg::action_t a, input logic led,
                                              input logic got, input logic ok,
                                              input logic [2:0] cmd, input logic [31:0] pw,
                                              input logic [17:0] rate);
    atcs_pkg::in_item_t it;
    it.action = a;
    it.led_level = led;
    it.rx_done = got;
    it.rx_match = ok;
    it.command = cmd;
    it.password = pw;
    it.baud_rate = rate;
    return it;
  endfunction

  // Expected result of a directed row; the link stays in command mode there.
  function automatic atcs_pkg::out_item_t directed_result(input logic pwr, input logic key,
                                                          input atcs_pkg::send_kind_t kind,
                                                          input logic [31:0] arg,
                                                          input logic [3:0] len,
                                                          input logic err,
                                                          input logic done,
                                                          input logic busy);
    atcs_pkg::out_item_t r;
    r.power_off = pwr;
    r.key_high = key;
    r.send_kind = kind;
    r.send_arg = arg;
    r.reply_length = len;
    r.link_mode = atcs_pkg::LINK_COMMAND;
    r.error = err;
    r.done_res = done;
    r.busy_res = busy;
    return r;
  endfunction

  function automatic void add_row(input atcs_pkg::in_item_t s, input bit typed,
                                  input atcs_pkg::out_item_t w);
    dir_row_t row;
    row.stim = s;
    row.typed = typed;
    row.want = w;
    dir_table.push_back(row);
  endfunction

  // Directed rows run at the reset configuration.
  function automatic void build_directed_table();
    atcs_pkg::out_item_t quiet;
    atcs_pkg::out_item_t busy;
    quiet = directed_result(0, 0, atcs_pkg::SEND_NONE, '0, '0, 0, 0, 0);
    busy = directed_result(0, 0, atcs_pkg::SEND_NONE, '0, '0, 0, 0, 1);
    add_row(stim(atcs_pkg::ACT_TICK, 1, 0, 0, atcs_pkg::CMD_RESET, '0, '0), 1, quiet);
    add_row(stim(atcs_pkg::ACT_NONE, 1, 1, 1, CMD_UNUSED_HI, 32'hFFFF_FFFF, 18'h3FFFF),
            1, quiet);
    add_row(stim(atcs_pkg::ACT_STEP, 0, 1, 1, atcs_pkg::CMD_RESET, '0, '0), 1, quiet);
    add_row(stim(atcs_pkg::ACT_START, 0, 0, 0, CMD_UNUSED_LO, 32'hFFFF_FFFF, 18'h3FFFF),
            1, quiet);
    add_row(stim(atcs_pkg::ACT_START, 0, 0, 0, CMD_UNUSED_HI, '0, '0), 1, quiet);
    // Handshake sent, then a reply that does not match.
    add_row(stim(atcs_pkg::ACT_START, 0, 0, 0, atcs_pkg::CMD_HANDSHAKE, '0, '0), 1, busy);
    add_row(stim(atcs_pkg::ACT_STEP, 0, 0, 0, atcs_pkg::CMD_RESET, '0, '0), 1,
            directed_result(0, 0, atcs_pkg::SEND_AT, '0, AT_REPLY, 0, 0, 1));
    add_row(stim(atcs_pkg::ACT_STEP, 0, 1, 0, atcs_pkg::CMD_RESET, '0, '0), 1, quiet);
    // All PIN bits set pass through; a baud start replaces the running sequence.
    add_row(stim(atcs_pkg::ACT_START, 0, 0, 0, atcs_pkg::CMD_SET_PIN, 32'hFFFF_FFFF, '0),
            1, busy);
    add_row(stim(atcs_pkg::ACT_STEP, 0, 0, 0, atcs_pkg::CMD_RESET, '0, '0), 1,
            directed_result(0, 0, atcs_pkg::SEND_PIN, 32'hFFFF_FFFF, PIN_REPLY, 0, 0, 1));
    add_row(stim(atcs_pkg::ACT_STEP, 0, 0, 1, atcs_pkg::CMD_RESET, '0, '0), 1, busy);
    add_row(stim(atcs_pkg::ACT_START, 0, 0, 0, atcs_pkg::CMD_SET_BAUD, '0, 18'd230400),
            1, busy);
    add_row(stim(atcs_pkg::ACT_STEP, 0, 0, 0, atcs_pkg::CMD_RESET, '0, '0), 1,
            directed_result(0, 0, atcs_pkg::SEND_BAUD, 32'd9, BAUD_REPLY, 0, 0, 1));
    add_row(stim(atcs_pkg::ACT_STEP, 0, 1, 1, atcs_pkg::CMD_RESET, '0, '0), 1, busy);
    // An unknown rate sends code zero.
    add_row(stim(atcs_pkg::ACT_START, 0, 0, 0, atcs_pkg::CMD_SET_BAUD, '0, 18'h3FFFF),
            1, busy);
    add_row(stim(atcs_pkg::ACT_STEP, 0, 0, 0, atcs_pkg::CMD_RESET, '0, '0), 1,
            directed_result(0, 0, atcs_pkg::SEND_BAUD, '0, BAUD_REPLY, 0, 0, 1));
    add_row(stim(atcs_pkg::ACT_START, 0, 0, 0, atcs_pkg::CMD_SET_PIN, '0, '0), 0, '0);
    add_row(stim(atcs_pkg::ACT_STEP, 0, 0, 0, atcs_pkg::CMD_RESET, '0, '0), 0, '0);
    add_row(stim(atcs_pkg::ACT_START, 1, 0, 0, atcs_pkg::CMD_SET_ROLE, '0, '0), 0, '0);
    add_row(stim(atcs_pkg::ACT_STEP, 1, 0, 0, atcs_pkg::CMD_RESET, '0, '0), 0, '0);
    add_row(stim(atcs_pkg::ACT_STEP, 0, 1, 1, atcs_pkg::CMD_RESET, '0, '0), 0, '0);
    // Reset sequence cuts power; a baud start then leaves the power line cut.
    add_row(stim(atcs_pkg::ACT_START, 0, 0, 0, atcs_pkg::CMD_RESET, '0, '0), 0, '0);
    add_row(stim(atcs_pkg::ACT_STEP, 0, 0, 0, atcs_pkg::CMD_RESET, '0, '0), 0, '0);
    add_row(stim(atcs_pkg::ACT_START, 0, 0, 0, atcs_pkg::CMD_SET_BAUD, '0, 18'd115200),
            0, '0);
    add_row(stim(atcs_pkg::ACT_STEP, 0, 0, 0, atcs_pkg::CMD_RESET, '0, '0), 0, '0);
  endfunction

  // Random phases: small timers for deep runs, plus both extremes.
  function automatic void plan_phases();
    phase_settings[0] = '{8'd1, 8'd3, 16'd12, 16'd6, 16'd5, 16'd4, 16'd6};
    phase_settings[1] = '{8'd0, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    phase_settings[2] = '{8'd0, 8'd0, 16'd5, 16'd3, 16'd4, 16'd2, 16'd3};
    phase_settings[3] = '{8'd2, 8'd4, 16'd10, 16'd8, 16'd6, 16'd5, 16'd7};
    phase_settings[4] = '{8'd1, 8'd3, 16'hFFFF, 16'd10, 16'd10, 16'd10, 16'd10};
    phase_settings[5] = '{8'd255, 8'd255, 16'd20, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    phase_settings[6] = '{8'd0, 8'd2, 16'd6, 16'd2, 16'd3, 16'd2, 16'd2};
  endfunction

  // Random item shaped by the predicted state so that sequences run to the end.
  function automatic atcs_pkg::in_item_t random_item();
    atcs_pkg::in_item_t it;
    logic [31:0] rnd;
    int pick;
    it.led_level = 1'($urandom_range(1));
    it.rx_done = ($urandom_range(99) < 45);
    it.rx_match = ($urandom_range(99) < 85);
    it.password = $urandom();
    rnd = $urandom();
    it.baud_rate = ($urandom_range(99) < 65) ? known_rates[$urandom_range(8)] : rnd[17:0];
    if ($urandom_range(99) < 8) begin
      it.command = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    end else begin
      it.command = 3'($urandom_range(atcs_pkg::CMD_SET_BAUD, atcs_pkg::CMD_RESET));
    end
    pick = $urandom_range(99);
    if (pick < 6) begin
      it.action = 2'($urandom_range(3));
    end else begin
      case (seq_state)
        atcs_pkg::S_IDLE:
          it.action = (pick < 70) ? atcs_pkg::ACT_START :
                      (pick < 85) ? atcs_pkg::ACT_TICK : atcs_pkg::ACT_STEP;
        atcs_pkg::S_PWR_WAIT, atcs_pkg::S_SETTLE, atcs_pkg::S_GAP, atcs_pkg::S_KEY_WAIT,
        atcs_pkg::S_DELAY_OFF, atcs_pkg::S_DELAY_ON: begin
          if (seq_timer == 0) begin
            it.action = (pick < 80) ? atcs_pkg::ACT_STEP : atcs_pkg::ACT_TICK;
          end else if (seq_timer <= 150) begin
            it.action = (pick < 90) ? atcs_pkg::ACT_TICK : atcs_pkg::ACT_STEP;
          end else begin
            it.action = (pick < 40) ? atcs_pkg::ACT_START :
                        (pick < 70) ? atcs_pkg::ACT_STEP : atcs_pkg::ACT_TICK;
          end
        end
        atcs_pkg::S_HS_WAIT, atcs_pkg::S_PIN_WAIT, atcs_pkg::S_ROLE_WAIT,
        atcs_pkg::S_BAUD_WAIT:
          it.action = (pick < 65) ? atcs_pkg::ACT_STEP :
                      (pick < 92) ? atcs_pkg::ACT_TICK : atcs_pkg::ACT_START;
        default:
          it.action = (pick < 80) ? atcs_pkg::ACT_STEP :
                      (pick < 92) ? atcs_pkg::ACT_TICK : atcs_pkg::ACT_START;
      endcase
    end
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Offers one item, with an optional idle gap before it, and records its result.
  task automatic offer_item(input atcs_pkg::in_item_t it, input bit typed,
                            input atcs_pkg::out_item_t want);
    atcs_pkg::out_item_t predicted;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = advance_sequencer(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Waits until every expected result has come and the pipeline is empty.
  task automatic drain();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input atcs_pkg::cfg_reg_t r, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    case (r)
      atcs_pkg::CFG_SAMPLE_PERIOD: c_period = v[7:0];
      atcs_pkg::CFG_WINDOW_SAMPLES: c_window = v[7:0];
      atcs_pkg::CFG_RESPONSE_TIMEOUT: c_resp = v;
      atcs_pkg::CFG_POWER_OFF_TIME: c_poff = v;
      atcs_pkg::CFG_POWER_SETTLE_TIME: c_settle = v;
      atcs_pkg::CFG_KEY_PULSE_TIME: c_key = v;
      atcs_pkg::CFG_COMMAND_GAP: c_gap = v;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input settings_t s);
    cfg_write(atcs_pkg::CFG_SAMPLE_PERIOD, {8'd0, s.period});
    cfg_write(atcs_pkg::CFG_WINDOW_SAMPLES, {8'd0, s.window});
    cfg_write(atcs_pkg::CFG_RESPONSE_TIMEOUT, s.resp);
    cfg_write(atcs_pkg::CFG_POWER_OFF_TIME, s.poff);
    cfg_write(atcs_pkg::CFG_POWER_SETTLE_TIME, s.settle);
    cfg_write(atcs_pkg::CFG_KEY_PULSE_TIME, s.keyt);
    cfg_write(atcs_pkg::CFG_COMMAND_GAP, s.gap);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
    end
  end

  // Each accepted result is compared with the oldest expected result.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item arrived with nothing expected");
      end else begin
        oldest = pending_results.pop_front();
        check_field("power_off", 32'(result.power_off), 32'(oldest.power_off));
        check_field("key_high", 32'(result.key_high), 32'(oldest.key_high));
        check_field("send_kind", 32'(result.send_kind), 32'(oldest.send_kind));
        check_field("send_arg", result.send_arg, oldest.send_arg);
        check_field("reply_length", 32'(result.reply_length), 32'(oldest.reply_length));
        check_field("link_mode", 32'(result.link_mode), 32'(oldest.link_mode));
        check_field("error", 32'(result.error), 32'(oldest.error));
        check_field("done_res", 32'(result.done_res), 32'(oldest.done_res));
        check_field("busy_res", 32'(result.busy_res), 32'(oldest.busy_res));
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Main sequence: reset, directed rows, then random phases.
  initial begin
    atcs_pkg::in_item_t it;
    int counted;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    build_directed_table();
    plan_phases();
    foreach (dir_table[i]) offer_item(dir_table[i].stim, dir_table[i].typed, dir_table[i].want);
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      apply_settings(phase_settings[p]);
      send_idle_pct = phase_send_idle[p];
      stall_pct = phase_stall[p];
      // The first phase opens with a long hold-off so the block backs up.
      if (p == 0) hold_req = ~hold_req;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        it = random_item();
        offer_item(it, 1'b0, '0);
        if (!(it.action == atcs_pkg::ACT_NONE ||
              (it.action == atcs_pkg::ACT_START && it.command > atcs_pkg::CMD_SET_BAUD)))
          counted++;
      end
    end
    drain();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
